@@ src/multi_channel_sonar_echo_timer_defines.svh @@
// assertion macros for the sonar echo timer
`ifndef MULTI_CHANNEL_SONAR_ECHO_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_SONAR_ECHO_TIMER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, expr)
`define ASSERT_IMPLIES(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ src/mcset_pkg.sv @@
package mcset_pkg;

    localparam int CHANNELS_DEF  = 4;
    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_W        = 32;
    localparam int TIMEOUT_W     = 20;
    localparam int DIST_W        = 31;
    localparam int MASK_W        = 4;
    localparam int CH_W          = 2;
    localparam int Q_W           = 15;
    localparam int Q_SHIFT       = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;
    // 0.34 mm/us in q16
    localparam logic [Q_W-1:0]       MM_PER_US_Q16 = 15'd22282;

    typedef enum logic [1:0] {
        OP_PING      = 2'd0,
        OP_ECHO      = 2'd1,
        OP_READ_TIME = 2'd2,
        OP_READ_DIST = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CH_W-1:0]  channel;
        logic [TIME_W-1:0] now_us;
    } in_t;

    typedef struct packed {
        logic [MASK_W-1:0] trigger_mask;
        logic [TIME_W-1:0] time_us;
        logic [DIST_W-1:0] distance_mm;
        logic              no_data;
    } out_t;

endpackage

@@ src/multi_channel_sonar_echo_timer.sv @@
// Ultrasonic time-of-flight capture for CHANNELS sensors. Each beat on the input
// channel is a ping, an echo or a read, stamped with a free-running microsecond
// time that wraps modulo 2^TIME_BITS; each beat gives exactly one result beat.
// The block takes one beat per cycle while the output is not stalled. Each beat
// goes from the input register through the channel state update (one subtract
// and one timeout compare per channel) into the second register, then through
// the constant multiply that turns time into millimetres (time * 22282 >> 16)
// into the output register. Up to three beats are held inside, so a stalled
// output blocks the input after three beats.
// Reset clears the waiting, armed and echo-time state; ping start times need no clearing.
// The timeout register is written through cfg_we/cfg_wdata; the user must write it only
// while no beat is in flight, as the block itself does not enforce this.
`include "multi_channel_sonar_echo_timer_defines.svh"

module multi_channel_sonar_echo_timer
    import mcset_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_beat
);

    localparam int PROD_W = TIME_BITS + Q_W;

    logic                 s1_valid_reg;
    in_t                  s1_beat_reg;
    logic                 s2_valid_reg;
    logic [MASK_W-1:0]    s2_mask_reg;
    logic [TIME_BITS-1:0] s2_t_reg;
    logic                 s2_nd_reg;
    logic                 out_valid_reg;
    out_t                 out_beat_reg;
    out_t                 out_beat_next;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [CHANNELS-1:0]  waiting_reg, waiting_next;
    logic [CHANNELS-1:0]  armed_reg, armed_next;
    logic [TIME_BITS-1:0] ping_start_reg [CHANNELS];
    logic [TIME_BITS-1:0] ping_start_next [CHANNELS];
    logic [TIME_BITS-1:0] echo_time_reg [CHANNELS];
    logic [TIME_BITS-1:0] echo_time_next [CHANNELS];

    logic                 out_free, s2_free, s1_fire, s2_fire;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed [CHANNELS];
    logic [CHANNELS-1:0]  late, sel, ping_hit;
    logic [CHANNELS+MASK_W-1:0] ping_hit_ext;

    logic                 hit, rd_wait, rd_late;
    logic [TIME_BITS-1:0] rd_el, rd_echo;
    logic [MASK_W-1:0]    s2_mask_next;
    logic [TIME_BITS-1:0] s2_t_next;
    logic                 s2_nd_next;
    logic [PROD_W-1:0]    prod;

    // handshake chain
    assign out_free  = !out_valid_reg || out_ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s2_fire   = s2_valid_reg && out_free;
    assign s1_fire   = s1_valid_reg && s2_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    assign now_t = s1_beat_reg.now_us[TIME_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            elapsed[i]  = now_t - ping_start_reg[i];
            late[i]     = TIME_W'(elapsed[i]) > TIME_W'(timeout_reg);
            sel[i]      = int'(s1_beat_reg.channel) == i;
            ping_hit[i] = !waiting_reg[i] || late[i];
        end
    end

    assign ping_hit_ext = {{MASK_W{1'b0}}, ping_hit};

    // selected channel read
    always_comb
    begin
        hit     = 1'b0;
        rd_wait = 1'b0;
        rd_late = 1'b0;
        rd_el   = '0;
        rd_echo = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (sel[i])
            begin
                hit     = 1'b1;
                rd_wait = waiting_reg[i];
                rd_late = late[i];
                rd_el   = elapsed[i];
                rd_echo = echo_time_reg[i];
            end
        end
    end

    // state update and result for the item in stage one
    always_comb
    begin
        waiting_next    = waiting_reg;
        armed_next      = armed_reg;
        ping_start_next = ping_start_reg;
        echo_time_next  = echo_time_reg;
        s2_mask_next    = '0;
        s2_t_next       = '0;
        s2_nd_next      = 1'b0;
        unique case (s1_beat_reg.op) inside
            OP_PING:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ping_hit[i])
                    begin
                        ping_start_next[i] = now_t;
                        waiting_next[i]    = 1'b1;
                        armed_next[i]      = 1'b1;
                    end
                end
                s2_mask_next = ping_hit_ext[MASK_W-1:0];
            end
            OP_ECHO:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (sel[i] && armed_reg[i])
                    begin
                        echo_time_next[i] = elapsed[i];
                        waiting_next[i]   = 1'b0;
                        armed_next[i]     = 1'b0;
                    end
                end
            end
            OP_READ_TIME, OP_READ_DIST:
            begin
                if (hit)
                begin
                    if (!rd_wait)
                        s2_t_next = rd_echo;
                    else if (rd_late)
                        s2_nd_next = 1'b1;
                    else
                        s2_t_next = rd_el;
                end
            end
            default:
            begin
                s2_mask_next = '0;
            end
        endcase
    end

    // millimetres from microseconds
    assign prod = PROD_W'(s2_t_reg) * PROD_W'(MM_PER_US_Q16);

    always_comb
    begin
        out_beat_next.trigger_mask = s2_mask_reg;
        out_beat_next.time_us      = TIME_W'(s2_t_reg);
        out_beat_next.distance_mm  = DIST_W'(prod >> Q_SHIFT);
        out_beat_next.no_data      = s2_nd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            waiting_reg   <= '0;
            armed_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
                echo_time_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
            if (s1_fire)
            begin
                waiting_reg   <= waiting_next;
                armed_reg     <= armed_next;
                echo_time_reg <= echo_time_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_beat_reg <= in_beat;
        if (s1_fire)
        begin
            ping_start_reg <= ping_start_next;
            s2_mask_reg    <= s2_mask_next;
            s2_t_reg       <= s2_t_next;
            s2_nd_reg      <= s2_nd_next;
        end
        if (s2_fire)
            out_beat_reg <= out_beat_next;
    end

    `ASSERT_ALWAYS(a_wait_armed_match, waiting_reg == armed_reg)
    `ASSERT_NEXT(a_s1_moves_to_s2, s1_fire, s2_valid_reg)
    `ASSERT_IMPLIES(a_nd_clears_time, s2_valid_reg && s2_nd_reg, s2_t_reg == '0 && s2_mask_reg == '0)
    `ASSERT_IMPLIES(a_mask_only_on_ping, s1_fire && s1_beat_reg.op != OP_PING, s2_mask_next == '0)
    `ASSERT_NEXT(a_ping_arms_all, s1_fire && s1_beat_reg.op == OP_PING, &waiting_reg)

endmodule
